[design/gle_pkg.sv]
// ----------------------------------------------------------------------------
// gle_pkg
// Shared types, constants and helpers of the GIF LZW encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package gle_pkg;

  localparam int HASH_SIZE_DEF     = 5003;
  localparam int MAX_CODE_BITS_DEF = 12;

  localparam int BYTE_W     = 8;
  localparam int MIN_W      = 4;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [MIN_W-1:0] MIN_RESET = 4'd8;
  localparam logic [MIN_W-1:0] MIN_LO    = 4'd2;
  localparam logic [MIN_W-1:0] MIN_HI    = 4'd8;

  // left shift applied to the pixel byte before it is xored with the prefix
  function automatic int hash_shift_f(input int hs);
    int f;
    int s;
    f = hs;
    s = 0;
    for (int k = 0; k < 17; k++) begin
      if (f < 65536) begin
        f = f * 2;
        s = s + 1;
      end
    end
    s = 8 - s;
    return (s < 0) ? 0 : s;
  endfunction

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;
    logic              stream_end;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_HASH,
    ST_PROBE,
    ST_EMIT,
    ST_DRAIN,
    ST_MISS,
    ST_SWEEP,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    CODE_CLEAR,
    CODE_PREFIX,
    CODE_EOF
  } code_sel_t;

  typedef enum logic [2:0] {
    RET_START,
    RET_MISS,
    RET_CLEAR,
    RET_PFX_LAST,
    RET_EOF
  } ret_t;

  typedef struct packed {
    logic      accept;
    logic      start;
    logic      hash;
    logic      advance;
    logic      hit;
    logic      emit;
    code_sel_t code_sel;
    logic      push;
    logic      add_entry;
    logic      clear_block;
    logic      sweep;
    logic      stream_done;
    logic      finish;
  } cmd_t;

  typedef struct packed {
    logic started;
    logic last;
    logic slot_used;
    logic key_match;
    logic probe_last;
    logic table_full;
    logic has_byte;
    logic can_push;
    logic pend_valid;
    logic sweep_done;
  } sts_t;

endpackage

`default_nettype wire

[design/gle_ram.sv]
// ----------------------------------------------------------------------------
// gle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/gle_ctrl.sv]
// ----------------------------------------------------------------------------
// gle_ctrl
// Sequencer: start, hash probe, code emission, byte drain, table sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module gle_ctrl import gle_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t    state_r, state_nxt;
  ret_t      ret_r, ret_nxt;
  code_sel_t sel_r, sel_nxt;
  logic      exh_r, exh_nxt;
  logic      end_r, end_nxt;

  // reset starts with a sweep of the hash table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SWEEP;
      ret_r   <= RET_START;
      sel_r   <= CODE_CLEAR;
      exh_r   <= 1'b0;
      end_r   <= 1'b1;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      sel_r   <= sel_nxt;
      exh_r   <= exh_nxt;
      end_r   <= end_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    sel_nxt   = sel_r;
    exh_nxt   = exh_r;
    end_nxt   = end_r;
    cmd       = '0;
    cmd.code_sel = sel_r;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          end_nxt    = 1'b0;
          state_nxt  = sts.started ? ST_HASH : ST_START;
        end
      end
      ST_START: begin
        cmd.start = 1'b1;
        sel_nxt   = CODE_CLEAR;
        ret_nxt   = RET_START;
        state_nxt = ST_EMIT;
      end
      ST_HASH: begin
        cmd.hash  = 1'b1;
        state_nxt = ST_PROBE;
      end
      ST_PROBE: begin
        priority if (!sts.slot_used) begin
          sel_nxt   = CODE_PREFIX;
          ret_nxt   = RET_MISS;
          exh_nxt   = 1'b0;
          state_nxt = ST_EMIT;
        end else if (sts.key_match) begin
          cmd.hit = 1'b1;
          if (sts.last) begin
            sel_nxt   = CODE_PREFIX;
            ret_nxt   = RET_PFX_LAST;
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_FINISH;
          end
        end else if (sts.probe_last) begin
          // probe sequence ran out: behaves as a full table
          sel_nxt   = CODE_PREFIX;
          ret_nxt   = RET_MISS;
          exh_nxt   = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      ST_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (sts.has_byte) begin
          cmd.push = sts.can_push;
        end else begin
          unique case (ret_r)
            RET_START: begin
              if (sts.last) begin
                sel_nxt   = CODE_PREFIX;
                ret_nxt   = RET_PFX_LAST;
                state_nxt = ST_EMIT;
              end else begin
                state_nxt = ST_FINISH;
              end
            end
            RET_MISS:  state_nxt = ST_MISS;
            RET_CLEAR: state_nxt = ST_SWEEP;
            RET_PFX_LAST: begin
              sel_nxt   = CODE_EOF;
              ret_nxt   = RET_EOF;
              state_nxt = ST_EMIT;
            end
            RET_EOF: begin
              cmd.stream_done = 1'b1;
              end_nxt         = 1'b1;
              state_nxt       = ST_SWEEP;
            end
            default: state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_MISS: begin
        if (exh_r || sts.table_full) begin
          cmd.clear_block = 1'b1;
          sel_nxt         = CODE_CLEAR;
          ret_nxt         = RET_CLEAR;
          state_nxt       = ST_EMIT;
        end else begin
          cmd.add_entry = 1'b1;
          if (sts.last) begin
            sel_nxt   = CODE_PREFIX;
            ret_nxt   = RET_PFX_LAST;
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_done) begin
          if (end_r) begin
            state_nxt = ST_FINISH;
          end else if (sts.last) begin
            sel_nxt   = CODE_PREFIX;
            ret_nxt   = RET_PFX_LAST;
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        if (!sts.pend_valid || sts.can_push) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[design/gle_dp.sv]
// ----------------------------------------------------------------------------
// gle_dp
// Datapath: code table, hash probe, bit packer and output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gle_dp import gle_pkg::*; #(
  parameter int HASH_SIZE     = HASH_SIZE_DEF,
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cmd_t             cmd,
  output sts_t                  sts,
  input  wire in_item_t         in_item,
  input  wire logic [MIN_W-1:0] min_code_size,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_item
);

  localparam int MCB    = MAX_CODE_BITS;
  localparam int IDX_W  = $clog2(HASH_SIZE);
  localparam int HW     = IDX_W + 1;
  localparam int KEY_W  = BYTE_W + MCB;
  localparam int WORD_W = 1 + KEY_W + MCB;
  localparam int NF_W   = MCB + 1;
  localparam int CW_W   = $clog2(MCB + 1);
  localparam int ACC_W  = MCB + BYTE_W;
  localparam int CNT_W  = $clog2(ACC_W);
  localparam int PRB_W  = $clog2(HASH_SIZE + 1);
  localparam int SHIFT  = hash_shift_f(HASH_SIZE);
  localparam logic [MIN_W-1:0] MIN_CAP = MIN_W'(MCB - 1);

  function automatic logic [NF_W-1:0] limit_f(input logic [CW_W-1:0] w);
    logic [NF_W-1:0] one;
    one = NF_W'(1);
    if (w >= CW_W'(MCB)) begin
      return one << MCB;
    end
    return (one << w) - one;
  endfunction

  logic [MIN_W-1:0]  cur_min_r;
  logic [MCB-1:0]    prefix_r;
  logic [NF_W-1:0]   nf_r;
  logic [CW_W-1:0]   cw_r;
  logic [NF_W-1:0]   limit_r;
  logic [ACC_W-1:0]  acc_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              pending_r;
  logic              started_r;
  logic              eof_r;
  logic [BYTE_W-1:0] c_raw_r;
  logic              last_r;
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  disp_r;
  logic [PRB_W-1:0]  prb_r;
  logic [IDX_W-1:0]  sweep_r;
  logic              pend_v_r;
  logic [BYTE_W-1:0] pend_r;
  logic              out_v_r;
  out_item_t         out_r;

  logic [MIN_W-1:0]  min_new;
  logic [MIN_W-1:0]  min_sel;
  logic [BYTE_W:0]   byte_mask;
  logic [BYTE_W-1:0] c_m;
  logic [MCB-1:0]    clr_sel;
  logic [HW-1:0]     h_raw;
  logic [HW-1:0]     h_mod;
  logic [IDX_W-1:0]  i_hash;
  logic [HW-1:0]     disp_w;
  logic [HW-1:0]     adv_w;
  logic [KEY_W-1:0]  key_cur;
  logic [MCB-1:0]    code_raw;
  logic [NF_W-1:0]   cw_mask;
  logic [MCB-1:0]    code_m;
  logic [ACC_W-1:0]  acc_emit;
  logic [CNT_W-1:0]  cnt_emit;
  logic [CW_W-1:0]   cw_new;
  logic              pending_new;
  logic              out_free;
  logic              can_push;
  logic              load_out;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  // minimum code size is clamped when a stream starts
  always_comb begin
    min_new = min_code_size;
    if (min_new < MIN_LO) min_new = MIN_LO;
    if (min_new > MIN_HI) min_new = MIN_HI;
    if (min_new > MIN_CAP) min_new = MIN_CAP;
  end

  assign min_sel   = cmd.start ? min_new : cur_min_r;
  assign byte_mask = ((BYTE_W + 1)'(1) << min_sel) - (BYTE_W + 1)'(1);
  assign c_m       = c_raw_r & byte_mask[BYTE_W-1:0];
  assign clr_sel   = MCB'(1) << min_sel;
  assign key_cur   = {c_m, prefix_r};

  // xor hash, one compare-subtract is a full modulo since the sum is below 2*HASH_SIZE
  assign h_raw  = (HW'(c_m) << SHIFT) ^ HW'(prefix_r);
  assign h_mod  = (h_raw >= HW'(HASH_SIZE)) ? h_raw - HW'(HASH_SIZE) : h_raw;
  assign i_hash = h_mod[IDX_W-1:0];
  assign disp_w = (i_hash == '0) ? HW'(1) : HW'(HASH_SIZE) - HW'(i_hash);
  assign adv_w  = (HW'(idx_r) >= HW'(disp_r)) ? HW'(idx_r) - HW'(disp_r)
                                              : HW'(idx_r) + HW'(HASH_SIZE) - HW'(disp_r);

  // code emission into the bit packer
  always_comb begin
    unique case (cmd.code_sel)
      CODE_CLEAR:  code_raw = clr_sel;
      CODE_PREFIX: code_raw = prefix_r;
      CODE_EOF:    code_raw = clr_sel + MCB'(1);
      default:     code_raw = '0;
    endcase
  end

  assign cw_mask  = (NF_W'(1) << cw_r) - NF_W'(1);
  assign code_m   = code_raw & cw_mask[MCB-1:0];
  assign acc_emit = (acc_r & ((ACC_W'(1) << cnt_r) - ACC_W'(1))) | (ACC_W'(code_m) << cnt_r);
  assign cnt_emit = cnt_r + CNT_W'(cw_r);

  always_comb begin
    cw_new      = cw_r;
    pending_new = pending_r;
    if (nf_r > limit_r || pending_r) begin
      if (pending_r) begin
        cw_new      = CW_W'(cur_min_r) + CW_W'(1);
        pending_new = 1'b0;
      end else if (cw_r < CW_W'(MCB)) begin
        cw_new = cw_r + CW_W'(1);
      end
    end
  end

  // one pending byte is held back so the last byte of an item can be tagged
  assign out_free = !out_v_r || out_ready;
  assign can_push = !pend_v_r || out_free;
  assign load_out = pend_v_r && ((cmd.push) || (cmd.finish && out_free));

  assign ram_we    = cmd.sweep || cmd.add_entry;
  assign ram_waddr = cmd.sweep ? sweep_r : idx_r;
  assign ram_wdata = cmd.sweep ? '0 : {1'b1, key_cur, nf_r[MCB-1:0]};
  assign ram_raddr = cmd.hash ? i_hash : (cmd.advance ? adv_w[IDX_W-1:0] : idx_r);

  gle_ram #(
    .WIDTH (WORD_W),
    .DEPTH (HASH_SIZE)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_min_r <= MIN_RESET;
      pending_r <= 1'b0;
      started_r <= 1'b0;
      eof_r     <= 1'b0;
      cnt_r     <= '0;
      sweep_r   <= '0;
      pend_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      if (cmd.start) begin
        cur_min_r <= min_new;
        nf_r      <= NF_W'(clr_sel) + NF_W'(2);
        cw_r      <= CW_W'(min_new) + CW_W'(1);
        limit_r   <= limit_f(CW_W'(min_new) + CW_W'(1));
        acc_r     <= '0;
        cnt_r     <= '0;
        pending_r <= 1'b0;
        started_r <= 1'b1;
        eof_r     <= 1'b0;
        prefix_r  <= MCB'(c_m);
      end
      if (cmd.accept) begin
        c_raw_r <= in_item.data_byte;
        last_r  <= in_item.last_byte;
      end
      if (cmd.hash) begin
        idx_r  <= i_hash;
        disp_r <= disp_w[IDX_W-1:0];
        prb_r  <= '0;
      end
      if (cmd.advance) begin
        idx_r <= adv_w[IDX_W-1:0];
        prb_r <= prb_r + PRB_W'(1);
      end
      if (cmd.hit) begin
        prefix_r <= ram_rdata[MCB-1:0];
      end
      if (cmd.emit) begin
        acc_r     <= acc_emit;
        cnt_r     <= cnt_emit;
        cw_r      <= cw_new;
        pending_r <= pending_new;
        limit_r   <= limit_f(cw_new);
        eof_r     <= (cmd.code_sel == CODE_EOF);
      end
      if (cmd.push) begin
        pend_r   <= acc_r[BYTE_W-1:0];
        pend_v_r <= 1'b1;
        acc_r    <= acc_r >> BYTE_W;
        cnt_r    <= (cnt_r >= CNT_W'(BYTE_W)) ? cnt_r - CNT_W'(BYTE_W) : '0;
      end
      if (cmd.add_entry) begin
        nf_r     <= nf_r + NF_W'(1);
        prefix_r <= MCB'(c_m);
      end
      if (cmd.clear_block) begin
        nf_r      <= NF_W'(clr_sel) + NF_W'(2);
        pending_r <= 1'b1;
        prefix_r  <= MCB'(c_m);
      end
      if (cmd.stream_done) begin
        started_r <= 1'b0;
      end
      if (cmd.sweep) begin
        sweep_r <= (sweep_r == IDX_W'(HASH_SIZE - 1)) ? '0 : sweep_r + IDX_W'(1);
      end
      if (cmd.finish && pend_v_r && out_free) begin
        pend_v_r <= 1'b0;
      end
      if (load_out) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r.out_byte   <= pend_r;
      out_r.run_last   <= cmd.finish;
      out_r.stream_end <= cmd.finish && last_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_item  = out_r;

  assign sts.started    = started_r;
  assign sts.last       = last_r;
  assign sts.slot_used  = ram_rdata[WORD_W-1];
  assign sts.key_match  = (ram_rdata[WORD_W-2 -: KEY_W] == key_cur);
  assign sts.probe_last = (prb_r == PRB_W'(HASH_SIZE));
  assign sts.table_full = (nf_r >= (NF_W'(1) << MCB));
  assign sts.has_byte   = (cnt_r >= CNT_W'(BYTE_W)) || (eof_r && cnt_r != '0);
  assign sts.can_push   = can_push;
  assign sts.pend_valid = pend_v_r;
  assign sts.sweep_done = (sweep_r == IDX_W'(HASH_SIZE - 1));

endmodule

`default_nettype wire

[design/gif_lzw_encoder_unit.sv]
// ----------------------------------------------------------------------------
// gif_lzw_encoder_unit
// GIF LZW encoder: pixel bytes in, LSB-first packed code stream bytes out.
// ----------------------------------------------------------------------------
//  channel   signals                         transfer
//  in        in_valid/in_ready, in_item      one pixel byte per request
//  out       out_valid/out_ready, out_item   one code stream byte per request
//  cfg       cfg_psel..cfg_prdata            min_code_size at address 0
//
//  A byte that hits in the table is hashed and probed in the table RAM;
//  each extra probe reads the table RAM again. Each emitted code is packed,
//  then its full bytes drain, and a miss also writes the table update. A
//  table clear or end of stream sweeps the table RAM, one entry per cycle
//  (HASH_SIZE entries, 5003 by default); reset runs the same sweep before
//  in_ready rises. A stalled out_ready holds the byte drain.
// ----------------------------------------------------------------------------
`default_nettype none

module gif_lzw_encoder_unit import gle_pkg::*; #(
  parameter int HASH_SIZE     = HASH_SIZE_DEF,
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_item,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_item,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  logic [MIN_W-1:0] min_code_size_r;
  cmd_t             cmd;
  sts_t             sts;

  // single register, so the address is not decoded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_code_size_r <= MIN_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      min_code_size_r <= cfg_pwdata[MIN_W-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == '0) ? CFG_DATA_W'(min_code_size_r)
                                        : CFG_DATA_W'(min_code_size_r);

  gle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gle_dp #(
    .HASH_SIZE     (HASH_SIZE),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_item       (in_item),
    .min_code_size (min_code_size_r),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_item      (out_item)
  );

endmodule

`default_nettype wire

[tb/lzw_stream_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lzw_stream_checker
// Watches the pixel, code stream and register ports of the GIF LZW encoder.
// It keeps its own copy of the code table and bit packer, works out the
// packed bytes for every accepted pixel request, and compares each output
// request in order.
// ----------------------------------------------------------------------------
module lzw_stream_checker import gle_pkg::*; #(
  parameter logic [CFG_ADDR_W-1:0] MIN_SIZE_ADDR = '0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_item,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_item,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  input  logic                  cfg_pready,
  output int                    mismatches,
  output int                    pending
);

  localparam int unsigned TBL_N     = 5003;
  localparam int unsigned CODE_BITS = 12;
  localparam int unsigned CODE_SPAN = 4096;
  // pixel shift for the xor hash: 5003 doubles 4 times to pass 65536, 8-4
  localparam int unsigned PIX_SHIFT = 4;

  logic [19:0] tbl_key  [TBL_N];
  logic [11:0] tbl_code [TBL_N];
  bit          tbl_used [TBL_N];

  int unsigned cur_prefix, free_code, code_w, grow_at, bit_buf, bit_cnt;
  int unsigned min_reg, min_live;
  bit          reset_width, in_stream;

  logic [7:0] step_bytes[$];
  out_item_t  code_bytes_q[$];

  function automatic int unsigned grow_limit(input int unsigned w);
    return (w >= CODE_BITS) ? CODE_SPAN : (32'd1 << w) - 1;
  endfunction

  task automatic put_byte(input int unsigned b);
    if (step_bytes.size() < 16) step_bytes.push_back(b[7:0]);
  endtask

  task automatic pack_code(input int unsigned code, input bit eof);
    int unsigned keep;
    keep = (bit_cnt >= 32) ? 32'hffff_ffff : (32'd1 << bit_cnt) - 1;
    code = code & ((32'd1 << code_w) - 1);
    bit_buf = (bit_buf & keep) | (code << bit_cnt);
    bit_cnt = bit_cnt + code_w;
    while (bit_cnt >= 8) begin
      put_byte(bit_buf);
      bit_buf = bit_buf >> 8;
      bit_cnt = bit_cnt - 8;
    end
    if (free_code > grow_at || reset_width) begin
      if (reset_width) begin
        code_w = min_live + 1;
        reset_width = 0;
      end else if (code_w < CODE_BITS) begin
        code_w = code_w + 1;
      end
      grow_at = grow_limit(code_w);
    end
    if (eof) begin
      while (bit_cnt > 0) begin
        put_byte(bit_buf);
        bit_buf = bit_buf >> 8;
        bit_cnt = (bit_cnt > 8) ? bit_cnt - 8 : 0;
      end
    end
    bit_buf = bit_buf & 32'h000f_ffff;
  endtask

  task automatic start_fresh();
    min_live = (min_reg < 2) ? 2 : (min_reg > 8) ? 8 : min_reg;
    foreach (tbl_used[k]) tbl_used[k] = 0;
    cur_prefix  = 0;
    free_code   = (32'd1 << min_live) + 2;
    code_w      = min_live + 1;
    grow_at     = grow_limit(code_w);
    bit_buf     = 0;
    bit_cnt     = 0;
    reset_width = 0;
    in_stream   = 0;
  endtask

  task automatic flush_table();
    foreach (tbl_used[k]) tbl_used[k] = 0;
    free_code   = (32'd1 << min_live) + 2;
    reset_width = 1;
    pack_code(32'd1 << min_live, 0);
  endtask

  task automatic extend_string(input int unsigned pix);
    int unsigned key, idx, disp;
    key  = (pix << CODE_BITS) + cur_prefix;
    idx  = (pix << PIX_SHIFT) ^ cur_prefix;
    if (idx >= TBL_N) idx = idx % TBL_N;
    disp = (idx == 0) ? 1 : TBL_N - idx;
    for (int unsigned n = 0; n <= TBL_N; n++) begin
      if (!tbl_used[idx]) begin
        pack_code(cur_prefix, 0);
        cur_prefix = pix;
        if (free_code < CODE_SPAN) begin
          tbl_used[idx] = 1;
          tbl_key[idx]  = key[19:0];
          tbl_code[idx] = free_code[11:0];
          free_code     = free_code + 1;
        end else begin
          flush_table();
        end
        return;
      end
      if (tbl_key[idx] == key[19:0]) begin
        cur_prefix = tbl_code[idx];
        return;
      end
      idx = (idx >= disp) ? idx - disp : idx + TBL_N - disp;
    end
    // probe sequence ran out: same as a full table
    pack_code(cur_prefix, 0);
    cur_prefix = pix;
    flush_table();
  endtask

  task automatic encode_pixel(input in_item_t it);
    int unsigned pix, cnt;
    out_item_t   exp_item;
    step_bytes.delete();
    if (!in_stream) begin
      start_fresh();
      in_stream = 1;
      pix = it.data_byte & ((32'd1 << min_live) - 1);
      pack_code(32'd1 << min_live, 0);
      cur_prefix = pix;
    end else begin
      pix = it.data_byte & ((32'd1 << min_live) - 1);
      extend_string(pix);
    end
    if (it.last_byte) begin
      pack_code(cur_prefix, 0);
      pack_code((32'd1 << min_live) + 1, 1);
      start_fresh();
    end
    cnt = (step_bytes.size() > 8) ? 8 : step_bytes.size();
    for (int unsigned k = 0; k < cnt; k++) begin
      exp_item.out_byte   = step_bytes[k];
      exp_item.run_last   = (k == cnt - 1);
      exp_item.stream_end = it.last_byte && (k == cnt - 1);
      code_bytes_q.push_back(exp_item);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      min_reg = 8;
      start_fresh();
      code_bytes_q.delete();
      mismatches <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (code_bytes_q.size() == 0) begin
          $error("unexpected output request: out_byte %0h", out_item.out_byte);
          mismatches <= mismatches + 1;
        end else begin
          out_item_t want;
          want = code_bytes_q.pop_front();
          if (want != out_item) mismatches <= mismatches + 1;
          if (want.out_byte != out_item.out_byte)
            $error("out_byte expected %0h actual %0h", want.out_byte, out_item.out_byte);
          if (want.run_last != out_item.run_last)
            $error("run_last expected %0b actual %0b", want.run_last, out_item.run_last);
          if (want.stream_end != out_item.stream_end)
            $error("stream_end expected %0b actual %0b", want.stream_end,
                   out_item.stream_end);
        end
      end
      if (in_valid && in_ready) encode_pixel(in_item);
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == MIN_SIZE_ADDR)
        min_reg = cfg_pwdata[3:0];
    end
    pending <= code_bytes_q.size();
  end

  initial begin
    mismatches = 0;
    pending    = 0;
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the GIF LZW encoder: directed short streams, random streams
// over several minimum code sizes, and one longer stream at the smallest
// code size that steps the code width up several times. Checking is done by
// lzw_stream_checker.
// ----------------------------------------------------------------------------
module tb;
  import gle_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] REG_MIN_SIZE = '0;
  localparam int CYCLE_LIMIT = 1_500_000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int mismatches, pending;
  int cycles = 0;
  int ready_pct = 100;
  int burst_left = 0;
  logic [7:0] prev_pix = '0;

  gif_lzw_encoder_unit i_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_item, .out_valid, .out_ready, .out_item,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata,
    .cfg_pready
  );

  lzw_stream_checker #(.MIN_SIZE_ADDR(REG_MIN_SIZE)) i_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_item, .out_valid, .out_ready, .out_item,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .mismatches, .pending
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stall pattern: out_ready is drawn at random against a changing ready percentage
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles % 400 == 0) begin
      case ($urandom_range(0, 3))
        0, 1: ready_pct <= 100;
        2: ready_pct <= 70;
        default: ready_pct <= 25;
      endcase
    end
    out_ready <= ($urandom_range(0, 99) < ready_pct);
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_pixel(input logic [7:0] pix, input logic last);
    if (burst_left == 0) begin
      if (in_valid) in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
    in_valid <= 1'b1;
    in_item  <= '{data_byte: pix, last_byte: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    prev_pix = pix;
    if (last) begin
      in_valid   <= 1'b0;
      burst_left = 0;
      @(posedge clk);
    end
  endtask

  // only between streams, once every byte has drained and the sweep is over
  task automatic set_min_size(input logic [3:0] val);
    wait (pending == 0);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= REG_MIN_SIZE;
    cfg_pwdata  <= {$urandom} & ~32'hf | val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_pixel(input int mode);
    case (mode)
      0: return 8'($urandom);
      1: return 8'($urandom_range(0, 3));
      default: return ($urandom_range(0, 1)) ? prev_pix : 8'($urandom_range(0, 7));
    endcase
  endfunction

  task automatic send_stream(input int len, input int mode);
    for (int k = 0; k < len; k++) send_pixel(pick_pixel(mode), k == len - 1);
  endtask

  initial begin
    int len, sz;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);

    // one-byte stream at the reset size, then runs of repeats and extremes
    send_pixel(8'h00, 1'b1);
    send_pixel(8'hff, 1'b0);
    send_pixel(8'hff, 1'b0);
    send_pixel(8'hff, 1'b0);
    send_pixel(8'hff, 1'b0);
    send_pixel(8'h80, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hff, 1'b1);
    set_min_size(4'd2);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h01, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h01, 1'b0);
    send_pixel(8'hfe, 1'b0);  // masked down to the low two bits
    send_pixel(8'h03, 1'b0);
    send_pixel(8'hff, 1'b1);
    set_min_size(4'd0);       // below range, clamps up
    send_pixel(8'h55, 1'b0);
    send_pixel(8'haa, 1'b1);
    set_min_size(4'd15);      // above range, clamps down
    send_pixel(8'h7f, 1'b0);
    send_pixel(8'h80, 1'b1);
    set_min_size(4'd5);
    send_stream(4, 2);

    sz = 0;
    while (sz < 100) begin
      if ($urandom_range(0, 2) == 0) set_min_size(4'($urandom));
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      send_stream(len, $urandom_range(0, 2));
      sz += len;
    end

    // longer stream at the smallest size: the code width steps up several times
    set_min_size(4'd2);
    send_stream(150, 0);

    wait (pending == 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
